/* src/fmbq_pkg.sv */
// shared types and constants for the front/middle/back queue
package fmbq_pkg;

    localparam int HALF_DEPTH = 512;
    localparam int ADDR_W     = $clog2(HALF_DEPTH);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int DATA_W     = 32;

    // total count at which a push is refused
    localparam logic [CNT_W:0] FULL_COUNT = (CNT_W + 1)'(2 * HALF_DEPTH);

    // ring size and last slot index for wrapping
    localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(HALF_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(HALF_DEPTH - 1);

    // request codes
    localparam logic [2:0] REQ_PUSH_FRONT  = 3'd0;
    localparam logic [2:0] REQ_PUSH_MIDDLE = 3'd1;
    localparam logic [2:0] REQ_PUSH_BACK   = 3'd2;
    localparam logic [2:0] REQ_POP_FRONT   = 3'd3;
    localparam logic [2:0] REQ_POP_MIDDLE  = 3'd4;
    localparam logic [2:0] REQ_POP_BACK    = 3'd5;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_NEG1,
        RES_FRONT,
        RES_BACK
    } res_sel_t;

    // work left for the finish step of a transaction
    typedef struct packed {
        logic              mv_en;
        logic              mv_to_front;
        logic [ADDR_W-1:0] mv_addr;
        res_sel_t          res_sel;
        logic [1:0]        status;
    } plan_t;

endpackage

/* src/fmbq_ram.sv */
// one ring memory: one write port, one registered read port
module fmbq_ram (
    input  logic                         clk,
    input  logic                         we,
    input  logic [fmbq_pkg::ADDR_W-1:0]  waddr,
    input  logic [fmbq_pkg::DATA_W-1:0]  wdata,
    input  logic                         re,
    input  logic [fmbq_pkg::ADDR_W-1:0]  raddr,
    output logic [fmbq_pkg::DATA_W-1:0]  rdata
);

    logic [fmbq_pkg::DATA_W-1:0] mem [fmbq_pkg::HALF_DEPTH];
    logic [fmbq_pkg::DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, old data on a same-address write, held while idle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/front_middle_back_queue.sv */
// top level of the front/middle/back queue
//
// A queue of 32-bit items with push and pop at the front, the middle and the
// back, held as two rings of 512 slots (front half and back half) in two
// synchronous memories. A transaction passes the read state and then the
// finish state: the first reads the ring memories and updates the head and
// count registers, the second takes the read data, writes the one item that
// crosses between the halves and loads the result register. A new request is
// accepted in the finish state, so a new transaction can start as one ends
// while results are taken; a waiting result stalls only the finish state of the
// following transaction. The memories need no clearing after reset. Pop on an
// empty queue returns -1 with status empty; push on a full queue (1024 items)
// is refused with status full; request codes 6 and 7 return 0 with status ok.
module front_middle_back_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pop_value,
    output logic [1:0]         status
);

    localparam int AW = fmbq_pkg::ADDR_W;
    localparam int CW = fmbq_pkg::CNT_W;
    localparam int DW = fmbq_pkg::DATA_W;

    fmbq_pkg::state_t state_reg, state_next;
    fmbq_pkg::plan_t  plan_reg, plan_next;

    logic [2:0]        req_reg;
    logic [DW-1:0]     value_reg;

    logic [AW-1:0]     fh_reg, fh_next, bh_reg, bh_next;
    logic [CW-1:0]     fc_reg, fc_next, bc_reg, bc_next;

    logic              out_valid_reg, out_valid_next;
    logic [DW-1:0]     pop_value_reg, pop_value_next;
    logic [1:0]        status_reg, status_next;

    logic [CW-1:0]     f_sum, b_sum;
    logic [AW-1:0]     f_end, f_last, b_end, b_last;
    logic [AW-1:0]     fh_dec, fh_inc, bh_dec, bh_inc;
    logic [CW:0]       total;
    logic              full, empty;

    logic              f_imm_we, b_imm_we, f_rd_en, b_rd_en;
    logic [AW-1:0]     f_imm_addr, b_imm_addr, f_rd_addr, b_rd_addr;

    logic              slot_free, finish, accept;

    logic              f_we, b_we, f_re, b_re;
    logic [AW-1:0]     f_waddr, b_waddr;
    logic [DW-1:0]     f_wdata, b_wdata, f_rdata, b_rdata;

    // ring index step back with wrap
    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] pos);
        return (pos == '0) ? fmbq_pkg::LAST_SLOT : pos - AW'(1);
    endfunction

    // ring index step forward with wrap
    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] pos);
        return (pos == fmbq_pkg::LAST_SLOT) ? '0 : pos + AW'(1);
    endfunction

    // ring positions
    assign f_sum  = CW'(fh_reg) + fc_reg;
    assign b_sum  = CW'(bh_reg) + bc_reg;
    assign f_end  = (f_sum >= fmbq_pkg::DEPTH_CNT) ? AW'(f_sum - fmbq_pkg::DEPTH_CNT)
                                                   : AW'(f_sum);
    assign b_end  = (b_sum >= fmbq_pkg::DEPTH_CNT) ? AW'(b_sum - fmbq_pkg::DEPTH_CNT)
                                                   : AW'(b_sum);
    assign f_last = ring_dec(f_end);
    assign b_last = ring_dec(b_end);
    assign fh_dec = ring_dec(fh_reg);
    assign fh_inc = ring_inc(fh_reg);
    assign bh_dec = ring_dec(bh_reg);
    assign bh_inc = ring_inc(bh_reg);

    assign total = {1'b0, fc_reg} + {1'b0, bc_reg};
    assign full  = (total >= fmbq_pkg::FULL_COUNT);
    assign empty = (total == '0);

    // decode the request into reads, direct writes, pointer updates and the move
    always_comb
    begin
        fh_next    = fh_reg;
        fc_next    = fc_reg;
        bh_next    = bh_reg;
        bc_next    = bc_reg;
        f_imm_we   = 1'b0;
        f_imm_addr = '0;
        b_imm_we   = 1'b0;
        b_imm_addr = '0;
        f_rd_en    = 1'b0;
        f_rd_addr  = '0;
        b_rd_en    = 1'b0;
        b_rd_addr  = '0;
        plan_next  = '{mv_en: 1'b0, mv_to_front: 1'b0, mv_addr: '0,
                       res_sel: fmbq_pkg::RES_ZERO, status: fmbq_pkg::STAT_OK};

        unique case (req_reg)
            fmbq_pkg::REQ_PUSH_FRONT:
            begin
                if (full)
                begin
                    plan_next.status = fmbq_pkg::STAT_FULL;
                end
                else if (fc_reg >= bc_reg)
                begin
                    // front half would get ahead: its last item goes to the back
                    fh_next = fh_dec;
                    bh_next = bh_dec;
                    bc_next = bc_reg + CW'(1);
                    if (fc_reg == '0)
                    begin
                        b_imm_we   = 1'b1;
                        b_imm_addr = bh_dec;
                    end
                    else
                    begin
                        f_imm_we          = 1'b1;
                        f_imm_addr        = fh_dec;
                        f_rd_en           = 1'b1;
                        f_rd_addr         = f_last;
                        plan_next.mv_en   = 1'b1;
                        plan_next.mv_addr = bh_dec;
                    end
                end
                else
                begin
                    f_imm_we   = 1'b1;
                    f_imm_addr = fh_dec;
                    fh_next    = fh_dec;
                    fc_next    = fc_reg + CW'(1);
                end
            end
            fmbq_pkg::REQ_PUSH_MIDDLE:
            begin
                if (full)
                begin
                    plan_next.status = fmbq_pkg::STAT_FULL;
                end
                else if (fc_reg >= bc_reg)
                begin
                    b_imm_we   = 1'b1;
                    b_imm_addr = bh_dec;
                    bh_next    = bh_dec;
                    bc_next    = bc_reg + CW'(1);
                end
                else
                begin
                    f_imm_we   = 1'b1;
                    f_imm_addr = f_end;
                    fc_next    = fc_reg + CW'(1);
                end
            end
            fmbq_pkg::REQ_PUSH_BACK:
            begin
                if (full)
                begin
                    plan_next.status = fmbq_pkg::STAT_FULL;
                end
                else
                begin
                    // the read of the first back item sees the old data
                    b_imm_we   = 1'b1;
                    b_imm_addr = b_end;
                    if (bc_reg > fc_reg)
                    begin
                        b_rd_en               = 1'b1;
                        b_rd_addr             = bh_reg;
                        plan_next.mv_en       = 1'b1;
                        plan_next.mv_to_front = 1'b1;
                        plan_next.mv_addr     = f_end;
                        bh_next               = bh_inc;
                        fc_next               = fc_reg + CW'(1);
                    end
                    else
                    begin
                        bc_next = bc_reg + CW'(1);
                    end
                end
            end
            fmbq_pkg::REQ_POP_FRONT:
            begin
                if (empty)
                begin
                    plan_next.res_sel = fmbq_pkg::RES_NEG1;
                    plan_next.status  = fmbq_pkg::STAT_EMPTY;
                end
                else if (fc_reg == '0)
                begin
                    b_rd_en           = 1'b1;
                    b_rd_addr         = bh_reg;
                    plan_next.res_sel = fmbq_pkg::RES_BACK;
                    bh_next           = bh_inc;
                    bc_next           = bc_reg - CW'(1);
                end
                else
                begin
                    f_rd_en           = 1'b1;
                    f_rd_addr         = fh_reg;
                    plan_next.res_sel = fmbq_pkg::RES_FRONT;
                    fh_next           = fh_inc;
                    if (bc_reg > fc_reg)
                    begin
                        // back half two ahead: its first item refills the front
                        b_rd_en               = 1'b1;
                        b_rd_addr             = bh_reg;
                        plan_next.mv_en       = 1'b1;
                        plan_next.mv_to_front = 1'b1;
                        plan_next.mv_addr     = f_end;
                        bh_next               = bh_inc;
                        bc_next               = bc_reg - CW'(1);
                    end
                    else
                    begin
                        fc_next = fc_reg - CW'(1);
                    end
                end
            end
            fmbq_pkg::REQ_POP_MIDDLE:
            begin
                if (empty)
                begin
                    plan_next.res_sel = fmbq_pkg::RES_NEG1;
                    plan_next.status  = fmbq_pkg::STAT_EMPTY;
                end
                else if (fc_reg == bc_reg)
                begin
                    f_rd_en           = 1'b1;
                    f_rd_addr         = f_last;
                    plan_next.res_sel = fmbq_pkg::RES_FRONT;
                    fc_next           = fc_reg - CW'(1);
                end
                else
                begin
                    b_rd_en           = 1'b1;
                    b_rd_addr         = bh_reg;
                    plan_next.res_sel = fmbq_pkg::RES_BACK;
                    bh_next           = bh_inc;
                    bc_next           = bc_reg - CW'(1);
                end
            end
            fmbq_pkg::REQ_POP_BACK:
            begin
                if (empty)
                begin
                    plan_next.res_sel = fmbq_pkg::RES_NEG1;
                    plan_next.status  = fmbq_pkg::STAT_EMPTY;
                end
                else
                begin
                    b_rd_en           = 1'b1;
                    b_rd_addr         = b_last;
                    plan_next.res_sel = fmbq_pkg::RES_BACK;
                    if (fc_reg >= bc_reg)
                    begin
                        // front half would get ahead: its last item goes to the back
                        f_rd_en           = 1'b1;
                        f_rd_addr         = f_last;
                        plan_next.mv_en   = 1'b1;
                        plan_next.mv_addr = bh_dec;
                        fc_next           = fc_reg - CW'(1);
                        bh_next           = bh_dec;
                    end
                    else
                    begin
                        bc_next = bc_reg - CW'(1);
                    end
                end
            end
            default:
            begin
                plan_next.status = fmbq_pkg::STAT_OK;
            end
        endcase
    end

    // sequencer, memory ports and result register
    always_comb
    begin
        slot_free  = !out_valid_reg || out_ready;
        finish     = (state_reg == fmbq_pkg::ST_FINISH) && slot_free;
        in_ready   = (state_reg == fmbq_pkg::ST_IDLE) || finish;
        accept     = in_valid && in_ready;
        state_next = state_reg;

        unique case (state_reg)
            fmbq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = fmbq_pkg::ST_READ;
                end
            end
            fmbq_pkg::ST_READ:
            begin
                state_next = fmbq_pkg::ST_FINISH;
            end
            fmbq_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = accept ? fmbq_pkg::ST_READ : fmbq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fmbq_pkg::ST_IDLE;
            end
        endcase

        // direct writes in the read cycle, the crossing item in the finish cycle
        f_we    = ((state_reg == fmbq_pkg::ST_READ) && f_imm_we)
                  || (finish && plan_reg.mv_en && plan_reg.mv_to_front);
        f_waddr = (state_reg == fmbq_pkg::ST_READ) ? f_imm_addr : plan_reg.mv_addr;
        f_wdata = (state_reg == fmbq_pkg::ST_READ) ? value_reg : b_rdata;
        b_we    = ((state_reg == fmbq_pkg::ST_READ) && b_imm_we)
                  || (finish && plan_reg.mv_en && !plan_reg.mv_to_front);
        b_waddr = (state_reg == fmbq_pkg::ST_READ) ? b_imm_addr : plan_reg.mv_addr;
        b_wdata = (state_reg == fmbq_pkg::ST_READ) ? value_reg : f_rdata;
        f_re    = (state_reg == fmbq_pkg::ST_READ) && f_rd_en;
        b_re    = (state_reg == fmbq_pkg::ST_READ) && b_rd_en;

        // result register
        out_valid_next = out_valid_reg && !out_ready;
        pop_value_next = pop_value_reg;
        status_next    = status_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
            status_next    = plan_reg.status;
            case (plan_reg.res_sel)
                fmbq_pkg::RES_NEG1:  pop_value_next = '1;
                fmbq_pkg::RES_FRONT: pop_value_next = f_rdata;
                fmbq_pkg::RES_BACK:  pop_value_next = b_rdata;
                default:             pop_value_next = '0;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fmbq_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            fh_reg        <= '0;
            fc_reg        <= '0;
            bh_reg        <= '0;
            bc_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == fmbq_pkg::ST_READ)
            begin
                fh_reg <= fh_next;
                fc_reg <= fc_next;
                bh_reg <= bh_next;
                bc_reg <= bc_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= req_type;
            value_reg <= $unsigned(value);
        end
        if (state_reg == fmbq_pkg::ST_READ)
        begin
            plan_reg <= plan_next;
        end
        pop_value_reg <= pop_value_next;
        status_reg    <= status_next;
    end

    // front half ring
    fmbq_ram u_front_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .re    (f_re),
        .raddr (f_rd_addr),
        .rdata (f_rdata)
    );

    // back half ring
    fmbq_ram u_back_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .re    (b_re),
        .raddr (b_rd_addr),
        .rdata (b_rdata)
    );

    assign out_valid = out_valid_reg;
    assign pop_value = $signed(pop_value_reg);
    assign status    = status_reg;

    // back half holds as many items as the front half or one more
    assert property (@(posedge clk) disable iff (!rst_n)
        (bc_reg == fc_reg) || (bc_reg == fc_reg + CW'(1)))
        else $error("halves out of balance");

    // never more items than both rings hold
    assert property (@(posedge clk) disable iff (!rst_n)
        total <= fmbq_pkg::FULL_COUNT)
        else $error("item count above capacity");

    // the read cycle is always followed by the finish cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fmbq_pkg::ST_READ) |=> (state_reg == fmbq_pkg::ST_FINISH))
        else $error("read cycle not followed by finish");

    // an empty pop reports minus one
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == fmbq_pkg::STAT_EMPTY)) |-> (pop_value == -32'sd1))
        else $error("empty pop without minus one");

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench for the front/middle/back queue
`timescale 1ns / 1ps

module tb_top;

    // request codes the block treats as no operation
    localparam logic [2:0]  REQ_UNUSED_6 = 3'd6;
    localparam logic [2:0]  REQ_UNUSED_7 = 3'd7;
    localparam logic [31:0] EMPTY_VALUE  = 32'hFFFF_FFFF;
    localparam int          QUEUE_CAP    = 2 * fmbq_pkg::HALF_DEPTH;
    localparam int          MAX_REPORTS  = 10;
    localparam int          QUIET_START  = 800;
    localparam int          QUIET_END    = 1600;
    localparam int          DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [2:0]  req;
        logic [31:0] val;
    } request_t;

    typedef struct packed {
        logic [31:0] pop_value;
        logic [1:0]  status;
    } result_t;

    logic               clk       = 1'b0;
    logic               rst_n;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [2:0]         req_type  = '0;
    logic signed [31:0] value     = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] pop_value;
    logic [1:0]         status;

    request_t    pending_requests[$];
    result_t     expected_results[$];
    logic [31:0] front_half[$];
    logic [31:0] back_half[$];
    request_t    cur_item;
    result_t     pred_res;
    result_t     exp_res;
    result_t     got_res;
    int          gen_len      = 0;
    int          total_items  = 0;
    int          accepted_cnt = 0;
    int          result_cnt   = 0;
    int          err_cnt      = 0;
    int          cycle_cnt    = 0;
    int          full_cnt     = 0;
    int          empty_cnt    = 0;
    int          peak_len     = 0;
    int          req_hits[8]  = '{default: 0};

    front_middle_back_queue DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pop_value (pop_value),
        .status    (status)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // random idle cycle, never inside the quiet window
    function automatic logic idle_now();
        if (cycle_cnt >= QUIET_START && cycle_cnt < QUIET_END)
            return 1'b0;
        return $urandom_range(99) < 10;
    endfunction

    // front half larger than back half: its last item moves to the back half
    task automatic rebalance_to_back();
        if (front_half.size() > back_half.size())
        begin
            back_half.insert(0, front_half[front_half.size() - 1]);
            front_half.delete(front_half.size() - 1);
        end
    endtask

    // queue behavior: updates both halves and returns the expected result
    task automatic apply_request(input request_t item, output result_t res);
        int total;
        total = front_half.size() + back_half.size();
        res.pop_value = '0;
        res.status    = fmbq_pkg::STAT_OK;
        case (item.req) inside
            fmbq_pkg::REQ_PUSH_FRONT, fmbq_pkg::REQ_PUSH_MIDDLE, fmbq_pkg::REQ_PUSH_BACK:
            begin
                if (total >= QUEUE_CAP)
                begin
                    res.status = fmbq_pkg::STAT_FULL;
                end
                else if (item.req == fmbq_pkg::REQ_PUSH_FRONT)
                begin
                    front_half.insert(0, item.val);
                    rebalance_to_back();
                end
                else if (item.req == fmbq_pkg::REQ_PUSH_MIDDLE)
                begin
                    front_half.insert(front_half.size(), item.val);
                    rebalance_to_back();
                end
                else
                begin
                    // back half ahead: its first item moves over before the append
                    if (back_half.size() > front_half.size())
                    begin
                        front_half.insert(front_half.size(), back_half[0]);
                        back_half.delete(0);
                    end
                    back_half.insert(back_half.size(), item.val);
                end
            end
            fmbq_pkg::REQ_POP_FRONT, fmbq_pkg::REQ_POP_MIDDLE, fmbq_pkg::REQ_POP_BACK:
            begin
                if (total == 0)
                begin
                    res.pop_value = EMPTY_VALUE;
                    res.status    = fmbq_pkg::STAT_EMPTY;
                end
                else if (item.req == fmbq_pkg::REQ_POP_FRONT)
                begin
                    if (front_half.size() == 0)
                    begin
                        res.pop_value = back_half[0];
                        back_half.delete(0);
                    end
                    else
                    begin
                        res.pop_value = front_half[0];
                        front_half.delete(0);
                        if (back_half.size() > front_half.size() + 1)
                        begin
                            front_half.insert(front_half.size(), back_half[0]);
                            back_half.delete(0);
                        end
                    end
                end
                else if (item.req == fmbq_pkg::REQ_POP_MIDDLE)
                begin
                    // even length takes the front-middle item
                    if (front_half.size() == back_half.size())
                    begin
                        res.pop_value = front_half[front_half.size() - 1];
                        front_half.delete(front_half.size() - 1);
                    end
                    else
                    begin
                        res.pop_value = back_half[0];
                        back_half.delete(0);
                    end
                end
                else
                begin
                    res.pop_value = back_half[back_half.size() - 1];
                    back_half.delete(back_half.size() - 1);
                    rebalance_to_back();
                end
            end
            default:
            begin
            end
        endcase
        if (front_half.size() + back_half.size() > peak_len)
            peak_len = front_half.size() + back_half.size();
    endtask

    // stimulus helpers: the generator tracks queue length to steer fill and drain
    task automatic add_item(input logic [2:0] req, input logic [31:0] val);
        request_t item;
        item.req = req;
        item.val = val;
        pending_requests.insert(pending_requests.size(), item);
        if (req <= fmbq_pkg::REQ_PUSH_BACK && gen_len < QUEUE_CAP)
            gen_len++;
        else if (req >= fmbq_pkg::REQ_POP_FRONT && req <= fmbq_pkg::REQ_POP_BACK
                 && gen_len > 0)
            gen_len--;
    endtask

    function automatic logic [2:0] pick_req(input int push_pct, input int unused_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < unused_pct)
            return $urandom_range(1) ? REQ_UNUSED_7 : REQ_UNUSED_6;
        if (roll < unused_pct + push_pct)
            return 3'($urandom_range(fmbq_pkg::REQ_PUSH_BACK, fmbq_pkg::REQ_PUSH_FRONT));
        return 3'($urandom_range(fmbq_pkg::REQ_POP_BACK, fmbq_pkg::REQ_POP_FRONT));
    endfunction

    // driver: presents pending transactions and predicts on acceptance
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                apply_request(cur_item, pred_res);
                expected_results.insert(expected_results.size(), pred_res);
                req_hits[cur_item.req]++;
                if (pred_res.status == fmbq_pkg::STAT_FULL)
                    full_cnt++;
                if (pred_res.status == fmbq_pkg::STAT_EMPTY)
                    empty_cnt++;
                accepted_cnt++;
            end
            if (in_valid && !in_ready)
            begin
                // hold the current transaction
            end
            else if (pending_requests.size() != 0 && !idle_now())
            begin
                cur_item = pending_requests[0];
                pending_requests.delete(0);
                in_valid <= 1'b1;
                req_type <= cur_item.req;
                value    <= cur_item.val;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stalls at random
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= !idle_now();
    end

    // monitor: each result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got_res.pop_value = pop_value;
            got_res.status    = status;
            result_cnt++;
            if (expected_results.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                    $display("unexpected result: pop_value %h status %0d",
                             got_res.pop_value, got_res.status);
            end
            else
            begin
                exp_res = expected_results[0];
                expected_results.delete(0);
                if (got_res.pop_value !== exp_res.pop_value
                    || got_res.status !== exp_res.status)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display({"mismatch on result %0d: pop_value exp %h got %h,",
                                  " status exp %0d got %0d"},
                                 result_cnt, exp_res.pop_value, got_res.pop_value,
                                 exp_res.status, got_res.status);
                end
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        rst_n = 1'b0;

        // directed: pops on empty, unused codes, extremes, both middle parities
        add_item(fmbq_pkg::REQ_POP_FRONT,   $urandom());
        add_item(fmbq_pkg::REQ_POP_MIDDLE,  $urandom());
        add_item(fmbq_pkg::REQ_POP_BACK,    $urandom());
        add_item(REQ_UNUSED_6,              $urandom());
        add_item(REQ_UNUSED_7,              32'hFFFF_FFFF);
        add_item(fmbq_pkg::REQ_PUSH_FRONT,  32'h7FFF_FFFF);
        add_item(fmbq_pkg::REQ_PUSH_BACK,   32'h8000_0000);
        add_item(fmbq_pkg::REQ_PUSH_MIDDLE, 32'h0000_0000);
        add_item(fmbq_pkg::REQ_PUSH_BACK,   32'hFFFF_FFFF);
        add_item(fmbq_pkg::REQ_PUSH_MIDDLE, 32'h5555_5555);
        add_item(fmbq_pkg::REQ_PUSH_FRONT,  32'hAAAA_AAAA);
        add_item(fmbq_pkg::REQ_POP_MIDDLE,  32'h0);
        add_item(fmbq_pkg::REQ_POP_MIDDLE,  32'h0);
        add_item(fmbq_pkg::REQ_POP_FRONT,   32'h0);
        add_item(fmbq_pkg::REQ_POP_BACK,    32'h0);
        add_item(fmbq_pkg::REQ_POP_MIDDLE,  32'h0);
        add_item(fmbq_pkg::REQ_POP_MIDDLE,  32'h0);
        add_item(fmbq_pkg::REQ_POP_MIDDLE,  32'h0);
        add_item(fmbq_pkg::REQ_PUSH_MIDDLE, 32'h1234_5678);
        add_item(fmbq_pkg::REQ_POP_BACK,    32'h0);

        // random: mixed traffic around empty, grow deep, hover, drain, mixed again
        repeat (250)
            add_item(pick_req(50, 5), $urandom());
        repeat (280)
            add_item(pick_req(80, 2), $urandom());
        repeat (60)
            add_item(pick_req(60, 0), $urandom());
        while (gen_len > 0)
            add_item(pick_req(5, 1), $urandom());
        repeat (140)
            add_item(pick_req(50, 5), $urandom());
        total_items = pending_requests.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_cnt < total_items || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display({"ran %0d requests: push f/m/b %0d/%0d/%0d,",
                  " pop f/m/b %0d/%0d/%0d, unused %0d"},
                 accepted_cnt, req_hits[fmbq_pkg::REQ_PUSH_FRONT],
                 req_hits[fmbq_pkg::REQ_PUSH_MIDDLE], req_hits[fmbq_pkg::REQ_PUSH_BACK],
                 req_hits[fmbq_pkg::REQ_POP_FRONT], req_hits[fmbq_pkg::REQ_POP_MIDDLE],
                 req_hits[fmbq_pkg::REQ_POP_BACK],
                 req_hits[REQ_UNUSED_6] + req_hits[REQ_UNUSED_7]);
        $display("refused full pushes %0d, pops on empty %0d, peak length %0d, mismatches %0d",
                 full_cnt, empty_cnt, peak_len, err_cnt);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial
    begin
        #300_000;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
src/fmbq_pkg.sv
src/fmbq_ram.sv
src/front_middle_back_queue.sv
tb/sv/tb_top.sv
